[src/ttpm_pkg.sv]
`default_nettype none

package ttpm_pkg;

  localparam int STORED_POINTS = 8;
  localparam int TRIP_WORDS    = 4;
  localparam int THR_BITS      = 16;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_ADDR_BITS = 6;
  localparam int LEVEL_BITS    = 3;

  localparam int DEF_MAX_TRIPS = 8;
  localparam int DEF_TEMP_BITS = 16;

  localparam logic [2:0] REG_TRIP_COUNT    = 3'd0;
  localparam logic [2:0] REG_THROTTLE_TEMP = 3'd1;
  localparam logic [2:0] REG_TRIP_WORDS_A  = 3'd2;
  localparam logic [2:0] REG_TRIP_WORDS_B  = 3'd3;
  localparam logic [2:0] REG_TRIP_WORDS_C  = 3'd4;
  localparam logic [2:0] REG_TRIP_WORDS_D  = 3'd5;

  localparam logic [3:0]  RESET_TRIP_COUNT    = 4'd1;
  localparam logic [15:0] RESET_THROTTLE_TEMP = 16'hFFFF;

  typedef struct packed {
    logic [3:0]                   trip_count;
    logic [THR_BITS-1:0]          throttle_temp;
    logic [TRIP_WORDS-1:0][63:0]  trip_words;
  } cfg_t;

  // sel 0: up threshold, sel 1: down threshold
  function automatic logic [THR_BITS-1:0] trip_threshold(cfg_t cfg, logic [2:0] point,
                                                         logic sel);
    logic [63:0] w;
    logic [5:0]  sh;
    w  = cfg.trip_words[point[2:1]];
    sh = {point[0], sel, 4'b0000};
    return w[sh +: THR_BITS];
  endfunction

endpackage

`default_nettype wire

[src/ttpm_regs.sv]
`default_nettype none

module ttpm_regs
  import ttpm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output cfg_t                          cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[CFG_ADDR_BITS-1:3];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trip_count    <= RESET_TRIP_COUNT;
      cfg.throttle_temp <= RESET_THROTTLE_TEMP;
      cfg.trip_words    <= '0;
    end else if (wr_en) begin
      case (reg_index)
        REG_TRIP_COUNT:    cfg.trip_count    <= pwdata[3:0];
        REG_THROTTLE_TEMP: cfg.throttle_temp <= pwdata[THR_BITS-1:0];
        REG_TRIP_WORDS_A:  cfg.trip_words[0] <= pwdata;
        REG_TRIP_WORDS_B:  cfg.trip_words[1] <= pwdata;
        REG_TRIP_WORDS_C:  cfg.trip_words[2] <= pwdata;
        REG_TRIP_WORDS_D:  cfg.trip_words[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_TRIP_COUNT:    prdata = {{(CFG_DATA_BITS-4){1'b0}}, cfg.trip_count};
      REG_THROTTLE_TEMP: prdata = {{(CFG_DATA_BITS-THR_BITS){1'b0}}, cfg.throttle_temp};
      REG_TRIP_WORDS_A:  prdata = cfg.trip_words[0];
      REG_TRIP_WORDS_B:  prdata = cfg.trip_words[1];
      REG_TRIP_WORDS_C:  prdata = cfg.trip_words[2];
      REG_TRIP_WORDS_D:  prdata = cfg.trip_words[3];
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/thermal_trip_point_monitor.sv]
`default_nettype none

// Thermal trip-point monitor with hysteresis. Takes one sample_temp transfer per clock
// when the result side is not stalled and returns exactly one result per sample
// (trip_level, notify, throttle): the sample is held in the input register, then the
// compare-and-update of the trip index and critical latch writes the result register. The
// throughput of one sample per cycle is set by that single update of the index and latch.
// Registers sit on an APB-style port at byte address 8*i (trip_count, throttle_temp,
// trip_words_a..d); write them only while the block is idle.

module thermal_trip_point_monitor
  import ttpm_pkg::*;
#(
  parameter int MAX_TRIPS = DEF_MAX_TRIPS,
  parameter int TEMP_BITS = DEF_TEMP_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output logic                          pready,
  input  wire logic                     sample_valid,
  output logic                          sample_ready,
  input  wire logic [15:0]              sample_temp,
  output logic                          result_valid,
  input  wire logic                     result_ready,
  output logic      [LEVEL_BITS-1:0]    trip_level,
  output logic                          notify,
  output logic                          throttle
);

  localparam int CMP_BITS = (TEMP_BITS < THR_BITS) ? TEMP_BITS : THR_BITS;
  localparam int MAX_POINTS = (MAX_TRIPS < STORED_POINTS) ? MAX_TRIPS : STORED_POINTS;
  localparam logic [3:0] MAX_N = 4'(MAX_POINTS);

  cfg_t cfg;

  ttpm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  logic                  s_valid;
  logic [CMP_BITS-1:0]   s_temp;
  logic [LEVEL_BITS-1:0] level;
  logic                  critical_done;
  logic                  advance;

  logic [3:0]            n_points;
  logic [LEVEL_BITS-1:0] top;
  logic [LEVEL_BITS-1:0] level_next;
  logic                  critical_done_next;
  logic                  throttle_next;
  logic [THR_BITS-1:0]   up_word;
  logic [THR_BITS-1:0]   dn_word;
  logic [CMP_BITS-1:0]   up_thr;
  logic [CMP_BITS-1:0]   dn_thr;
  logic [CMP_BITS-1:0]   crit_thr;

  assign advance      = s_valid && (!result_valid || result_ready);
  assign sample_ready = !s_valid || advance;

  always_comb begin
    n_points = cfg.trip_count;
    if (n_points == 4'd0) begin
      n_points = 4'd1;
    end
    if (n_points > MAX_N) begin
      n_points = MAX_N;
    end
    top = 3'(n_points - 4'd1);
  end

  assign up_word  = trip_threshold(cfg, 3'(level + 3'd1), 1'b0);
  assign dn_word  = trip_threshold(cfg, level, 1'b1);
  assign up_thr   = up_word[CMP_BITS-1:0];
  assign dn_thr   = dn_word[CMP_BITS-1:0];
  assign crit_thr = cfg.throttle_temp[CMP_BITS-1:0];

  always_comb begin
    level_next         = level;
    critical_done_next = critical_done;
    throttle_next      = 1'b0;
    if (level < top && s_temp >= up_thr) begin
      level_next = 3'(level + 3'd1);
    end else if (level != '0 && s_temp < dn_thr) begin
      level_next = 3'(level - 3'd1);
      if (level == top) begin
        critical_done_next = 1'b0;
      end
    end else if (level == top && s_temp >= crit_thr && !critical_done) begin
      critical_done_next = 1'b1;
      throttle_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (sample_ready) begin
      s_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      s_temp <= sample_temp[CMP_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level         <= '0;
      critical_done <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (advance) begin
        level         <= level_next;
        critical_done <= critical_done_next;
        result_valid  <= 1'b1;
      end else if (result_ready) begin
        result_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trip_level <= level_next;
      notify     <= (level_next != level);
      throttle   <= throttle_next;
    end
  end

  // throttle never coincides with an index change
  assert property (@(posedge clk) disable iff (rst)
    result_valid && throttle |-> !notify)
    else $error("throttle with notify");

  // throttle always leaves the latch set
  assert property (@(posedge clk) disable iff (rst)
    advance && throttle_next |=> critical_done)
    else $error("latch not set on throttle");

  // index moves at most one point per sample
  assert property (@(posedge clk) disable iff (rst)
    advance |=> (level == $past(level)) || (level == 3'($past(level) + 3'd1)) ||
                (level == 3'($past(level) - 3'd1)))
    else $error("trip index jumped");

  // the result register reports the live index
  assert property (@(posedge clk) disable iff (rst)
    advance |=> trip_level == level)
    else $error("result index mismatch");

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench
  import ttpm_pkg::*;
();

  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam int PHASES       = 16;
  localparam int PHASE_ITEMS  = 100;
  localparam int STALL_LIMIT  = 1000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  notify;
    logic                  throttle;
  } trip_result_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_CHECKED, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic [2:0]   reg_idx;
    logic [63:0]  data;
    trip_result_t res;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [40] = '{
    '{ROW_CHECKED, '0, 64'h0000, '{3'd0, 1'b0, 1'b0}},
    '{ROW_CHECKED, '0, 64'hFFFF, '{3'd0, 1'b0, 1'b1}},
    '{ROW_CHECKED, '0, 64'hFFFF, '{3'd0, 1'b0, 1'b0}},
    '{ROW_WRITE, REG_TRIP_COUNT, 64'd4, '0},
    '{ROW_WRITE, REG_THROTTLE_TEMP, 64'h0900, '0},
    '{ROW_WRITE, REG_TRIP_WORDS_A, 64'h00F0_0100_0000_0000, '0},
    '{ROW_WRITE, REG_TRIP_WORDS_B, 64'h07F0_0800_01F0_0200, '0},
    '{ROW_SAMPLE, '0, 64'h0100, '0},
    '{ROW_SAMPLE, '0, 64'h00EF, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    '{ROW_SAMPLE, '0, 64'h07EF, '0},
    '{ROW_SAMPLE, '0, 64'h0800, '0},
    '{ROW_SAMPLE, '0, 64'h0900, '0},
    // level left above the top point
    '{ROW_WRITE, REG_TRIP_COUNT, 64'd2, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    '{ROW_SAMPLE, '0, 64'h0000, '0},
    '{ROW_SAMPLE, '0, 64'h0000, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    // zero count acts as one point
    '{ROW_WRITE, REG_TRIP_COUNT, 64'hFFFF_FFFF_FFFF_FFF0, '0},
    '{ROW_WRITE, REG_THROTTLE_TEMP, 64'h0000, '0},
    '{ROW_SAMPLE, '0, 64'h0000, '0},
    '{ROW_SAMPLE, '0, 64'h0000, '0},
    // oversized count saturates to eight points
    '{ROW_WRITE, REG_TRIP_COUNT, 64'hA5A5_0000_0000_000F, '0},
    '{ROW_WRITE, REG_THROTTLE_TEMP, 64'hFFFF, '0},
    '{ROW_WRITE, REG_TRIP_WORDS_C, 64'h03F0_0400_02F0_0300, '0},
    '{ROW_WRITE, REG_TRIP_WORDS_D, 64'hFFFF_FFFF_04F0_0500, '0},
    '{ROW_WRITE, REG_SPARE_6, 64'hDEAD_BEEF_0000_0001, '0},
    '{ROW_WRITE, REG_SPARE_7, 64'h0123_4567_89AB_CDEF, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    '{ROW_SAMPLE, '0, 64'hFFFE, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0},
    '{ROW_SAMPLE, '0, 64'hFFFF, '0}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     sample_valid = 1'b0;
  logic                     sample_ready;
  logic [15:0]              sample_temp = '0;
  logic                     result_valid;
  logic                     result_ready = 1'b0;
  logic [LEVEL_BITS-1:0]    trip_level;
  logic                     notify;
  logic                     throttle;

  thermal_trip_point_monitor u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_temp  (sample_temp),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .trip_level   (trip_level),
    .notify       (notify),
    .throttle     (throttle)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cfg_t            trip_cfg;
  logic [2:0]      level_now;
  bit              latch_now;
  trip_result_t    expected_results[$];
  trip_result_t    level_want;
  bit              gaps_on = 1'b1;
  int              mismatch_count = 0;
  int              samples_sent = 0;
  int              results_seen = 0;
  int              writes_done = 0;
  int              throttles_seen = 0;
  int              changes_seen = 0;
  int              idle_cycles = 0;

  function automatic logic [15:0] clamp16(input int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic int top_point();
    int n;
    n = trip_cfg.trip_count;
    if (n == 0) n = 1;
    if (n > DEF_MAX_TRIPS) n = DEF_MAX_TRIPS;
    if (n > STORED_POINTS) n = STORED_POINTS;
    return n - 1;
  endfunction

  function automatic logic [15:0] point_limit(input int point, input bit down);
    logic [63:0] w;
    w = trip_cfg.trip_words[point / 2];
    return w[(point % 2) * 32 + (down ? 16 : 0) +: 16];
  endfunction

  function automatic trip_result_t advance_trip_state(input logic [15:0] temp);
    int           top;
    int           cur;
    int           nxt;
    bit           pulse;
    trip_result_t r;
    top   = top_point();
    cur   = level_now;
    nxt   = cur;
    pulse = 1'b0;
    if (cur < top && temp >= point_limit(cur + 1, 1'b0)) begin
      nxt = cur + 1;
    end else if (cur != 0 && temp < point_limit(cur, 1'b1)) begin
      nxt = cur - 1;
      if (cur == top) latch_now = 1'b0;
    end else if (cur == top && temp >= trip_cfg.throttle_temp && !latch_now) begin
      latch_now = 1'b1;
      pulse     = 1'b1;
    end
    level_now  = nxt[2:0];
    r.level    = nxt[2:0];
    r.notify   = (nxt != cur);
    r.throttle = pulse;
    return r;
  endfunction

  function automatic logic [15:0] pick_probe_temp();
    int cur;
    int r;
    int base;
    cur = level_now;
    r   = $urandom_range(99);
    if (r < 30 && cur < 7) base = point_limit(cur + 1, 1'b0);
    else if (r < 55) base = point_limit(cur, 1'b1);
    else if (r < 68) base = trip_cfg.throttle_temp;
    else if (r < 78) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    else return 16'($urandom_range(65535));
    return clamp16(base + int'($urandom_range(4)) - 2);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TRIP_COUNT:    trip_cfg.trip_count = val[3:0];
      REG_THROTTLE_TEMP: trip_cfg.throttle_temp = val[15:0];
      REG_TRIP_WORDS_A:  trip_cfg.trip_words[0] = val;
      REG_TRIP_WORDS_B:  trip_cfg.trip_words[1] = val;
      REG_TRIP_WORDS_C:  trip_cfg.trip_words[2] = val;
      REG_TRIP_WORDS_D:  trip_cfg.trip_words[3] = val;
      default: ;
    endcase
    writes_done++;
    @(posedge clk);
  endtask

  task automatic push_sample(input logic [15:0] temp, input bit checked,
                             input trip_result_t want);
    trip_result_t predicted;
    if (gaps_on) begin
      while ($urandom_range(99) < 31) begin
        sample_valid <= 1'b0;
        @(posedge clk);
      end
    end
    sample_valid <= 1'b1;
    sample_temp  <= temp;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    predicted = advance_trip_state(temp);
    expected_results.push_back(checked ? want : predicted);
    samples_sent++;
  endtask

  // hold the sender until every result is back
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_random_trips(input int phase);
    logic [15:0] up [8];
    logic [15:0] dn [8];
    logic [63:0] words [4];
    logic [3:0]  count;
    logic [15:0] crit;
    int          step;
    int          base;
    int          top;
    step = $urandom_range(4000, 16);
    base = $urandom_range(1000);
    for (int p = 0; p < 8; p++) begin
      up[p] = clamp16(base + p * step + int'($urandom_range(step / 2)));
      dn[p] = clamp16(int'(up[p]) - int'($urandom_range(step)));
    end
    for (int i = 0; i < 4; i++) begin
      if (phase % 5 == 4) words[i] = {32'($urandom), 32'($urandom)};
      else words[i] = {dn[2*i+1], up[2*i+1], dn[2*i], up[2*i]};
    end
    case (phase)
      0: count = 4'd8;
      1: count = 4'd1;
      2: count = 4'd0;
      3: count = 4'd15;
      default: begin
        if ($urandom_range(3) == 0) count = 4'($urandom_range(15));
        else count = 4'($urandom_range(8, 2));
      end
    endcase
    top = (count == 0) ? 0 : ((count > 8) ? 7 : count - 1);
    case (phase)
      1: crit = 16'h0000;
      2: crit = 16'hFFFF;
      default: crit = clamp16(int'(up[top]) + int'($urandom_range(step)) - step / 4);
    endcase
    write_reg(REG_TRIP_WORDS_A, words[0]);
    write_reg(REG_TRIP_WORDS_B, words[1]);
    write_reg(REG_TRIP_WORDS_C, words[2]);
    write_reg(REG_TRIP_WORDS_D, words[3]);
    write_reg(REG_TRIP_COUNT, {32'($urandom), 28'($urandom), count});
    write_reg(REG_THROTTLE_TEMP, {32'($urandom), 16'($urandom), crit});
    if (phase % 4 == 3) begin
      write_reg(REG_SPARE_6, {32'($urandom), 32'($urandom)});
      write_reg(REG_SPARE_7, {32'($urandom), 32'($urandom)});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (throttle === 1'b1) throttles_seen++;
        if (notify === 1'b1) changes_seen++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result with nothing pending: level %0d notify %b throttle %b",
                     $realtime, trip_level, notify, throttle);
        end else begin
          level_want = expected_results.pop_front();
          if (trip_level !== level_want.level || notify !== level_want.notify ||
              throttle !== level_want.throttle) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: result %0d expected level %0d notify %b throttle %b, got %0d %b %b",
                       $realtime, results_seen, level_want.level, level_want.notify,
                       level_want.throttle, trip_level, notify, throttle);
          end
        end
      end
      result_ready <= !gaps_on || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results still pending",
                 STALL_LIMIT, expected_results.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    bit        backlog;
    trip_cfg.trip_count    = RESET_TRIP_COUNT;
    trip_cfg.throttle_temp = RESET_THROTTLE_TEMP;
    trip_cfg.trip_words    = '0;
    level_now = '0;
    latch_now = 1'b0;
    backlog   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        if (backlog) drain_results();
        backlog = 1'b0;
        write_reg(row.reg_idx, row.data);
      end else begin
        push_sample(row.data[15:0], row.kind == ROW_CHECKED, row.res);
        backlog = 1'b1;
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      program_random_trips(phase);
      gaps_on = !(phase >= 6 && phase <= 8);
      for (int k = 0; k < PHASE_ITEMS; k++) push_sample(pick_probe_temp(), 1'b0, '0);
    end

    gaps_on = 1'b1;
    drain_results();
    repeat (4) @(posedge clk);
    $display("%0d samples, %0d results checked across %0d trip settings (%0d register writes)",
             samples_sent, results_seen, PHASES + 5, writes_done);
    $display("%0d level changes and %0d throttle pulses observed, %0d mismatches",
             changes_seen, throttles_seen, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
